### sv/bdpc_pkg.sv
`timescale 1ns / 1ps

package bdpc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned IDX_W  = 2;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd1;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ev_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic              take_event;
        logic [TIME_W-1:0] now_ms;
        logic              raw_pressed;
    } in_word_t;

    typedef struct packed {
        logic pressed;
        ev_t  event_res;
    } res_t;

endpackage

### sv/button_debounce_press_classifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Word layout (lowest bit first)
// s_axis    in         raw_pressed [0], now_ms [32:1], take_event [33], zero [39:34]
// m_axis    out        event_res [1:0], pressed [2], zero [7:3]
// cfg       in         cfg_index 0 debounce_time, 1 long_press_time; no read-back
//
// Each word passes through an input register and then a result register, and its result
// is offered on m_axis once it sits in the result register; one word is taken per cycle
// while m_axis does not stall.
// The button state is updated in the cycle a word moves from the input register to the
// result register. When m_axis stalls, the result register holds and the input register
// still takes one more word. Reset restores register defaults, clears valids and core state.

module button_debounce_press_classifier
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bdpc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // raw_pressed, now_ms, take_event
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bdpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // event_res, pressed
    input  logic                             cfg_wr_en,
    input  logic [bdpc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]       cfg_data
);
    import bdpc_pkg::*;

    localparam int unsigned IN_W = $bits(in_word_t);
    localparam int unsigned RES_W = $bits(res_t);

    cfg_t     cfg;
    res_t     res;
    logic     step;
    logic     in_take;

    logic     in_vld_reg;
    logic     in_vld_next;
    in_word_t in_word_reg;
    logic     out_vld_reg;
    logic     out_vld_next;
    res_t     out_res_reg;

    bdpc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bdpc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .word  (in_word_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign step          = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_vld_next  = in_take || (in_vld_reg && !step);
        out_vld_next = step || (out_vld_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_word_t'(s_axis_tdata[IN_W-1:0]);
        end
        if (step)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_reg};

endmodule

### sv/bdpc_cfg.sv
`timescale 1ns / 1ps

module bdpc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [bdpc_pkg::IDX_W-1:0]  wr_index,
    input  logic [bdpc_pkg::CFG_W-1:0]  wr_data,
    output bdpc_pkg::cfg_t              cfg
);
    import bdpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_DEBOUNCE:   cfg_next.debounce_time   = wr_data;
                REG_LONG_PRESS: cfg_next.long_press_time = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEBOUNCE_RST;
            cfg_reg.long_press_time <= LONG_PRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bdpc_core.sv
`timescale 1ns / 1ps

module bdpc_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bdpc_pkg::in_word_t  word,
    input  bdpc_pkg::cfg_t      cfg,
    output bdpc_pkg::res_t      res
);
    import bdpc_pkg::*;

    logic              last_raw_reg;
    logic              last_raw_next;
    logic              stable_reg;
    logic              stable_next;
    logic [TIME_W-1:0] change_stamp_reg;
    logic [TIME_W-1:0] change_stamp_next;
    logic [TIME_W-1:0] press_stamp_reg;
    logic [TIME_W-1:0] press_stamp_next;
    logic              held_reg;
    logic              held_next;
    logic              long_fired_reg;
    logic              long_fired_next;
    ev_t               pending_reg;
    ev_t               pending_next;

    logic              settled;
    logic              rise;
    logic              fall;
    logic              long_hit;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    ev_t               ev;

    always_comb
    begin
        last_raw_next     = word.raw_pressed;
        change_stamp_next = (word.raw_pressed != last_raw_reg) ? word.now_ms : change_stamp_reg;
        since_change      = word.now_ms - change_stamp_next;
        settled           = since_change >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time};

        rise = settled && word.raw_pressed && !stable_reg;
        fall = settled && !word.raw_pressed && stable_reg;

        stable_next      = settled ? word.raw_pressed : stable_reg;
        press_stamp_next = rise ? word.now_ms : press_stamp_reg;
        held_next        = rise ? 1'b1 : held_reg;
        long_fired_next  = rise ? 1'b0 : long_fired_reg;

        since_press = word.now_ms - press_stamp_next;
        long_hit    = settled && word.raw_pressed && held_next && !long_fired_next
                      && (since_press >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_time});

        ev = pending_reg;
        if (long_hit)
        begin
            ev              = EV_LONG;
            long_fired_next = 1'b1;
        end
        if (fall)
        begin
            held_next = 1'b0;
            if (!long_fired_next)
            begin
                ev = EV_SHORT;
            end
        end

        pending_next = word.take_event ? EV_NONE : ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b0;
            stable_reg       <= 1'b0;
            change_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            held_reg         <= 1'b0;
            long_fired_reg   <= 1'b0;
            pending_reg      <= EV_NONE;
        end
        else if (step)
        begin
            last_raw_reg     <= last_raw_next;
            stable_reg       <= stable_next;
            change_stamp_reg <= change_stamp_next;
            press_stamp_reg  <= press_stamp_next;
            held_reg         <= held_next;
            long_fired_reg   <= long_fired_next;
            pending_reg      <= pending_next;
        end
    end

    assign res.event_res = ev;
    assign res.pressed   = stable_next;

endmodule

### tb/sv/button_debounce_press_classifier_test.sv
`timescale 1ns / 1ps

module button_debounce_press_classifier_test;

    import bdpc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // Indexes beyond the register map; writes to them must change nothing.
    localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    logic [IN_TDATA_W-1:0] poll_q[$];
    res_t                  press_results_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_cnt = 0;
    int err_cnt = 0;
    int queued_cnt = 0;
    int accepted_cnt = 0;
    int short_cnt = 0;
    int long_cnt = 0;
    int unsigned clock_ms = 0;

    // Predictor state and its copy of the registers.
    logic [CFG_W-1:0]  dbnc_ms = DEBOUNCE_RST;
    logic [CFG_W-1:0]  long_ms = LONG_PRESS_RST;
    logic              seen_raw = 1'b0;
    logic              settled = 1'b0;
    logic [TIME_W-1:0] edge_ms = '0;
    logic [TIME_W-1:0] press_ms = '0;
    logic              holding = 1'b0;
    logic              long_done = 1'b0;
    ev_t               latched_ev = EV_NONE;

    button_debounce_press_classifier u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic res_t classify_poll(in_word_t w);
        res_t              r;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] since_press;
        logic              was_down;
        if (w.raw_pressed != seen_raw)
            edge_ms = w.now_ms;
        seen_raw = w.raw_pressed;
        since_edge = w.now_ms - edge_ms;
        if (since_edge >= {16'd0, dbnc_ms})
        begin
            was_down = settled;
            settled = w.raw_pressed;
            if (settled && !was_down)
            begin
                press_ms = w.now_ms;
                holding = 1'b1;
                long_done = 1'b0;
            end
            since_press = w.now_ms - press_ms;
            if (settled && holding && !long_done && since_press >= {16'd0, long_ms})
            begin
                latched_ev = EV_LONG;
                long_done = 1'b1;
            end
            if (!settled && was_down)
            begin
                holding = 1'b0;
                if (!long_done)
                    latched_ev = EV_SHORT;
            end
        end
        r.event_res = latched_ev;
        r.pressed = settled;
        if (w.take_event)
            latched_ev = EV_NONE;
        if (r.event_res == EV_SHORT)
            short_cnt++;
        if (r.event_res == EV_LONG)
            long_cnt++;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (poll_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tdata  <= poll_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[2:0];
                if (press_results_q.size() == 0)
                begin
                    $error("result word with no expectation pending: event_res %0d pressed %0d",
                           got.event_res, got.pressed);
                    err_cnt++;
                end
                else
                begin
                    want = press_results_q.pop_front();
                    if (got.event_res !== want.event_res)
                    begin
                        $error("event_res: expected %0d, actual %0d",
                               want.event_res, got.event_res);
                        err_cnt++;
                    end
                    if (got.pressed !== want.pressed)
                    begin
                        $error("pressed: expected %0d, actual %0d", want.pressed, got.pressed);
                        err_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted_cnt++;
                press_results_q.push_back(classify_poll(s_axis_tdata[33:0]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("button_debounce_press_classifier: mismatch");
            $finish;
        end
    end

    task automatic add_poll(input logic raw, input logic [TIME_W-1:0] now, input logic take);
        in_word_t w;
        w.raw_pressed = raw;
        w.now_ms = now;
        w.take_event = take;
        poll_q.push_back({6'd0, w});
        queued_cnt++;
    endtask

    task automatic step_poll(input logic raw, input int unsigned adv);
        clock_ms = clock_ms + adv;
        add_poll(raw, clock_ms, $urandom_range(0, 3) == 0);
    endtask

    // One press and release with contact bounce on both edges and random hold lengths.
    task automatic add_session();
        int unsigned jitter;
        int unsigned hold_ms;
        int unsigned n;
        jitter = dbnc_ms / 2 + 2;
        repeat ($urandom_range(0, 3))
            step_poll(1'($urandom_range(0, 1)), $urandom_range(0, jitter));
        n = $urandom_range(1, 5);
        hold_ms = $urandom_range(0, dbnc_ms + long_ms + long_ms / 2 + 4);
        repeat (n)
            step_poll(1'b1, hold_ms / n + $urandom_range(0, 2));
        repeat ($urandom_range(0, 3))
            step_poll(1'($urandom_range(0, 1)), $urandom_range(0, jitter));
        n = $urandom_range(1, 4);
        hold_ms = $urandom_range(0, 2 * dbnc_ms + 4);
        repeat (n)
            step_poll(1'b0, hold_ms / n + $urandom_range(0, 2));
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 1) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms - $urandom_range(1, dbnc_ms + 5);
                add_poll(1'($urandom_range(0, 1)), clock_ms, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (poll_q.size() != 0 || s_axis_tvalid || press_results_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DEBOUNCE)
            dbnc_ms = val;
        else if (idx == REG_LONG_PRESS)
            long_ms = val;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dbnc, input logic [CFG_W-1:0] lp,
                             input int send_pct, input int recv_pct, input int n_polls,
                             input int pause_after);
        int  start;
        bit  paused;
        wait_idle();
        write_reg(REG_DEBOUNCE, dbnc);
        write_reg(REG_LONG_PRESS, lp);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        clock_ms = $urandom;
        start = queued_cnt;
        paused = 1'b0;
        while (queued_cnt - start < n_polls)
        begin
            add_session();
            if (pause_after != 0 && !paused && queued_cnt - start >= pause_after)
            begin
                wait_idle();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: a bounced press held into a long event, a short press,
        // an untaken event, a wrap through zero and a timestamp that steps back.
        add_poll(1'b0, 32'd0, 1'b0);
        add_poll(1'b1, 32'd100, 1'b0);
        add_poll(1'b1, 32'd149, 1'b0);
        add_poll(1'b1, 32'd150, 1'b0);
        add_poll(1'b0, 32'd160, 1'b0);
        add_poll(1'b1, 32'd165, 1'b0);
        add_poll(1'b1, 32'd1149, 1'b0);
        add_poll(1'b1, 32'd1150, 1'b1);
        add_poll(1'b0, 32'd1200, 1'b0);
        add_poll(1'b0, 32'd1250, 1'b1);
        add_poll(1'b1, 32'd2000, 1'b0);
        add_poll(1'b1, 32'd2050, 1'b0);
        add_poll(1'b0, 32'd2100, 1'b0);
        add_poll(1'b0, 32'd2150, 1'b0);
        add_poll(1'b0, 32'd2160, 1'b1);
        add_poll(1'b0, 32'd2170, 1'b1);
        add_poll(1'b1, 32'hFFFF_FFFF, 1'b0);
        add_poll(1'b1, 32'h0000_0031, 1'b0);
        add_poll(1'b0, 32'h0000_0040, 1'b0);
        add_poll(1'b0, 32'h0000_0030, 1'b0);
        add_poll(1'b0, 32'h0000_0030, 1'b1);
        add_poll(1'b1, 32'h5555_5555, 1'b1);
        add_poll(1'b0, 32'hAAAA_AAAA, 1'b1);
        clock_ms = 32'hAAAA_AAAA;
        while (queued_cnt < 250)
            add_session();

        run_phase(16'd0, 16'd0, 76, 0, 230, 0);
        run_phase(16'hFFFF, 16'hFFFF, 0, 76, 230, 0);
        run_phase(16'($urandom_range(1, 20)), 16'($urandom_range(1, 80)), 14, 14, 230, 110);
        wait_idle();
        write_reg(REG_SPARE_A, 16'($urandom));
        write_reg(REG_SPARE_B, 16'($urandom));
        run_phase(16'd0, 16'($urandom_range(1, 50)), 0, 0, 220, 0);
        run_phase(16'($urandom), 16'($urandom), 76, 0, 230, 0);
        run_phase(16'd3, 16'd8, 14, 14, 230, 0);

        wait_idle();
        repeat (8) @(posedge clk);
        $display("Checked %0d polls over seven register settings and four idling patterns,",
                 accepted_cnt);
        $display("with %0d short and %0d long press reports among the results.",
                 short_cnt, long_cnt);
        if (err_cnt == 0)
            $display("button_debounce_press_classifier: match");
        else
            $display("button_debounce_press_classifier: mismatch");
        $finish;
    end

endmodule

### sim.f
sv/bdpc_pkg.sv
sv/bdpc_cfg.sv
sv/bdpc_core.sv
sv/button_debounce_press_classifier.sv
tb/sv/button_debounce_press_classifier_test.sv
